// File: rtl/core/csgi_pkg.sv
// ----------------------------------------------------------------------------
// csgi_pkg
// Shared types and codes for the circular scan gap interpolator.
// ----------------------------------------------------------------------------
package csgi_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // result source codes
  typedef enum logic [1:0] {
    SRC_MEASURED = 2'd0,
    SRC_INTERP   = 2'd1,
    SRC_NONE     = 2'd2
  } source_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_MODE = 1'd1;

  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_DATA_W-1:0] BINS_RESET = 10'd512;

  // stored word: {known, range}
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned WORD_W  = RANGE_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_RD_T,
    S_RD_TW,
    S_B_ISS,
    S_B_CHK,
    S_F_ISS,
    S_F_CHK,
    S_MUL,
    S_DIV,
    S_SUM,
    S_FIN
  } state_e;

  typedef struct packed {
    logic cap_item;
    logic clr_inc;
    logic ram_clr_we;
    logic ram_wr_we;
    logic ram_rd;
    logic rd_sel_pos;
    logic res_masked;
    logic res_stored;
    logic init_back;
    logic init_fwd;
    logic step_back;
    logic step_fwd;
    logic cap_prev;
    logic cap_next;
    logic mul;
    logic div_step;
    logic sum;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  in_ring;
    logic  known;
    logic  linear;
    logic  scan_end;
    logic  clr_last;
    logic  div_done;
    logic  out_free;
  } status_t;

endpackage

// File: rtl/core/csgi_ram.sv
// ----------------------------------------------------------------------------
// csgi_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module csgi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/csgi_ctrl.sv
// ----------------------------------------------------------------------------
// csgi_ctrl
// Sequencer: clear sweep, write, read with ring walk and serial divide.
// ----------------------------------------------------------------------------
module csgi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  csgi_pkg::status_t  status_i,
  output csgi_pkg::cmd_t     cmd_o
);

  csgi_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csgi_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csgi_pkg::S_CLEAR: begin
        if (status_i.clr_last) state_d = csgi_pkg::S_IDLE;
      end
      csgi_pkg::S_IDLE: begin
        if (in_valid_i) state_d = csgi_pkg::S_RD_T;
      end
      csgi_pkg::S_RD_T: begin
        // item captured last cycle; dispatch on kind
        unique case (status_i.kind)
          csgi_pkg::KIND_CLEAR: state_d = csgi_pkg::S_CLEAR;
          csgi_pkg::KIND_WRITE: state_d = csgi_pkg::S_WRITE;
          csgi_pkg::KIND_READ:  state_d = status_i.in_ring ? csgi_pkg::S_RD_TW
                                                           : csgi_pkg::S_FIN;
          default:              state_d = csgi_pkg::S_IDLE;
        endcase
      end
      csgi_pkg::S_WRITE: state_d = csgi_pkg::S_IDLE;
      csgi_pkg::S_RD_TW: begin
        if (status_i.known || !status_i.linear) state_d = csgi_pkg::S_FIN;
        else                                    state_d = csgi_pkg::S_B_ISS;
      end
      csgi_pkg::S_B_ISS: begin
        state_d = status_i.scan_end ? csgi_pkg::S_FIN : csgi_pkg::S_B_CHK;
      end
      csgi_pkg::S_B_CHK: begin
        state_d = status_i.known ? csgi_pkg::S_F_ISS : csgi_pkg::S_B_ISS;
      end
      csgi_pkg::S_F_ISS: begin
        state_d = status_i.scan_end ? csgi_pkg::S_FIN : csgi_pkg::S_F_CHK;
      end
      csgi_pkg::S_F_CHK: begin
        state_d = status_i.known ? csgi_pkg::S_MUL : csgi_pkg::S_F_ISS;
      end
      csgi_pkg::S_MUL: state_d = csgi_pkg::S_DIV;
      csgi_pkg::S_DIV: begin
        if (status_i.div_done) state_d = csgi_pkg::S_SUM;
      end
      csgi_pkg::S_SUM: state_d = csgi_pkg::S_FIN;
      csgi_pkg::S_FIN: begin
        if (status_i.out_free) state_d = csgi_pkg::S_IDLE;
      end
      default: state_d = csgi_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      csgi_pkg::S_CLEAR: begin
        cmd_o.ram_clr_we = 1'b1;
        cmd_o.clr_inc    = 1'b1;
      end
      csgi_pkg::S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.cap_item = in_valid_i;
      end
      csgi_pkg::S_RD_T: begin
        cmd_o.ram_rd     = 1'b1;
        cmd_o.res_masked = 1'b1;
      end
      csgi_pkg::S_WRITE: begin
        cmd_o.ram_wr_we = status_i.in_ring;
      end
      csgi_pkg::S_RD_TW: begin
        cmd_o.res_stored = status_i.known;
        cmd_o.init_back  = 1'b1;
      end
      csgi_pkg::S_B_ISS: begin
        cmd_o.ram_rd     = 1'b1;
        cmd_o.rd_sel_pos = 1'b1;
      end
      csgi_pkg::S_B_CHK: begin
        cmd_o.cap_prev  = status_i.known;
        cmd_o.init_fwd  = status_i.known;
        cmd_o.step_back = !status_i.known;
      end
      csgi_pkg::S_F_ISS: begin
        cmd_o.ram_rd     = 1'b1;
        cmd_o.rd_sel_pos = 1'b1;
      end
      csgi_pkg::S_F_CHK: begin
        cmd_o.cap_next = status_i.known;
        cmd_o.step_fwd = !status_i.known;
      end
      csgi_pkg::S_MUL: cmd_o.mul      = 1'b1;
      csgi_pkg::S_DIV: cmd_o.div_step = 1'b1;
      csgi_pkg::S_SUM: cmd_o.sum      = 1'b1;
      csgi_pkg::S_FIN: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/csgi_datapath.sv
// ----------------------------------------------------------------------------
// csgi_datapath
// Bin store, config registers, ring walker, multiplier and serial divider.
// ----------------------------------------------------------------------------
module csgi_datapath #(
  parameter int unsigned MAX_BINS = 512
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [1:0]                           kind_i,
  input  logic [8:0]                           bin_index_i,
  input  logic signed [16:0]                   range_value_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic signed [16:0]                   range_out_o,
  output logic [1:0]                           source_o,
  input  logic                                 cfg_we_i,
  input  logic [csgi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [csgi_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  csgi_pkg::cmd_t                       cmd_i,
  output csgi_pkg::status_t                    status_o
);

  localparam int unsigned AW   = $clog2(MAX_BINS);
  localparam int unsigned LW   = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int unsigned PW   = csgi_pkg::RANGE_W + AW + 1;
  localparam int unsigned CNTW = $clog2(PW + 1);
  localparam logic [AW-1:0]   CLR_LAST = AW'(MAX_BINS - 1);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(PW - 1);

  // config
  logic [csgi_pkg::CFG_DATA_W-1:0] bins_q;
  logic                            lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= csgi_pkg::BINS_RESET;
      lin_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == csgi_pkg::CFG_BINS_IN_USE) bins_q <= cfg_data_i;
      if (cfg_idx_i == csgi_pkg::CFG_LINEAR_MODE) lin_q  <= cfg_data_i[0];
    end
  end

  // ring size, clamped to 1..MAX_BINS
  logic [LW-1:0] bins_x, n_x;
  logic [AW:0]   ring_n, n_m1;

  always_comb begin
    bins_x = LW'(bins_q);
    if (bins_x == '0)                   n_x = LW'(1);
    else if (bins_x > LW'(MAX_BINS))    n_x = LW'(MAX_BINS);
    else                                n_x = bins_x;
    ring_n = n_x[AW:0];
    n_m1   = ring_n - (AW+1)'(1);
  end

  // captured item
  logic [1:0]         kind_q;
  logic [8:0]         idx_q;
  logic signed [16:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      kind_q <= kind_i;
      idx_q  <= bin_index_i;
      val_q  <= range_value_i;
    end
  end

  logic [AW-1:0] idx_a, last_a;
  assign idx_a  = AW'(idx_q);
  assign last_a = n_m1[AW-1:0];

  // clear pointer
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_inc) begin
      clr_q <= (clr_q == CLR_LAST) ? '0 : clr_q + AW'(1);
    end
  end

  // walk position and distance
  logic [AW-1:0] pos_q, pos_d;
  logic [AW:0]   d_q, d_d;

  always_comb begin
    pos_d = pos_q;
    d_d   = d_q;
    if (cmd_i.init_back) begin
      pos_d = (idx_a == '0) ? last_a : idx_a - AW'(1);
      d_d   = (AW+1)'(1);
    end else if (cmd_i.init_fwd) begin
      pos_d = (idx_a == last_a) ? '0 : idx_a + AW'(1);
      d_d   = (AW+1)'(1);
    end else if (cmd_i.step_back) begin
      pos_d = (pos_q == '0) ? last_a : pos_q - AW'(1);
      d_d   = d_q + (AW+1)'(1);
    end else if (cmd_i.step_fwd) begin
      pos_d = (pos_q == last_a) ? '0 : pos_q + AW'(1);
      d_d   = d_q + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    d_q   <= d_d;
  end

  // bin store: {known, range}
  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [csgi_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    ram_we = cmd_i.ram_clr_we | cmd_i.ram_wr_we;
    if (cmd_i.ram_clr_we)     ram_addr = clr_q;
    else if (cmd_i.rd_sel_pos) ram_addr = pos_q;
    else                       ram_addr = idx_a;
    if (cmd_i.ram_clr_we) ram_wdata = '0;
    else                  ram_wdata = {~val_q[16], val_q[15:0]};
  end

  csgi_ram #(
    .WIDTH (csgi_pkg::WORD_W),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.ram_rd),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // neighbors, multiply, divide
  logic [15:0]     prev_q, next_q;
  logic [AW:0]     dp_q, den_q;
  logic            neg_q;
  logic [PW-1:0]   dvd_q;
  logic [AW:0]     rem_q;
  logic [CNTW-1:0] cnt_q;

  logic [16:0]     diff, mag;
  logic [AW+1:0]   rem_sh, rem_sub;
  logic            ge;

  always_comb begin
    diff    = {1'b0, next_q} - {1'b0, prev_q};
    mag     = diff[16] ? -diff : diff;
    rem_sh  = {rem_q, dvd_q[PW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_prev) begin
      prev_q <= ram_rdata[15:0];
      dp_q   <= d_q;
    end
    if (cmd_i.cap_next) begin
      next_q <= ram_rdata[15:0];
      den_q  <= dp_q + d_q;
    end
    if (cmd_i.mul) begin
      neg_q <= diff[16];
      // full-width product: magnitude times backward distance
      dvd_q <= PW'(mag[15:0]) * PW'(dp_q);
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[AW:0] : rem_sh[AW:0];
      dvd_q <= {dvd_q[PW-2:0], ge};
      cnt_q <= cnt_q + CNTW'(1);
    end
  end

  // result and output register
  logic signed [16:0] res_q, q17;
  logic [1:0]         src_q;
  logic               out_valid_q;
  logic signed [16:0] out_range_q;
  logic [1:0]         out_src_q;

  assign q17 = {1'b0, dvd_q[15:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_masked) begin
      res_q <= -17'sd1;
      src_q <= csgi_pkg::SRC_NONE;
    end
    if (cmd_i.res_stored) begin
      res_q <= {1'b0, ram_rdata[15:0]};
      src_q <= csgi_pkg::SRC_MEASURED;
    end
    if (cmd_i.sum) begin
      res_q <= $signed({1'b0, prev_q}) + (neg_q ? -q17 : q17);
      src_q <= csgi_pkg::SRC_INTERP;
    end
    if (cmd_i.out_load) begin
      out_range_q <= res_q;
      out_src_q   <= src_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign range_out_o = out_range_q;
  assign source_o    = out_src_q;

  always_comb begin
    status_o.kind     = csgi_pkg::kind_e'(kind_q);
    status_o.in_ring  = LW'(idx_q) < n_x;
    status_o.known    = ram_rdata[16];
    status_o.linear   = lin_q;
    status_o.scan_end = LW'(d_q) >= n_x;
    status_o.clr_last = clr_q == CLR_LAST;
    status_o.div_done = cnt_q == CNT_LAST;
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

endmodule

// File: rtl/core/circular_scan_gap_interpolator.sv
// ----------------------------------------------------------------------------
// circular_scan_gap_interpolator
// Ring of range bins with clear, write and read; in linear mode, reads of
// masked bins are interpolated linearly between the nearest known neighbors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: kind,
//   bin_index, range_value. Only reads give a result, on the output channel
//   (out_valid_o / out_stall_i) as range_out and source.
//   One request is in flight at a time; in_stall_o is low only when idle.
//   A write passes S_RD_T and S_WRITE; a clear sweeps all MAX_BINS words to
//   masked, one RAM word cleared per cycle. A read fetches its bin; a known
//   bin, a masked bin in masked mode or an index outside the ring ends the
//   read in S_FIN with no walk. Otherwise the read walks back, then forward
//   to the nearest known bins, then multiplies, divides and sums. Each walk
//   bin takes an issue and a check state (single RAM port, registered read);
//   the divider gives one quotient bit per cycle.
//   After reset the block sweeps all MAX_BINS words to masked before it
//   takes a request; configuration writes are taken at any time.
//   A result waits in the output register while the receiver stalls; the
//   next request is taken meanwhile, and its result holds until the
//   register frees up.
// ----------------------------------------------------------------------------
module circular_scan_gap_interpolator #(
  parameter int unsigned MAX_BINS = 512
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       kind_i,
  input  logic [8:0]                       bin_index_i,
  input  logic signed [16:0]               range_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [16:0]               range_out_o,
  output logic [1:0]                       source_o,
  input  logic                             cfg_we_i,
  input  logic [csgi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [csgi_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  csgi_pkg::cmd_t    cmd;
  csgi_pkg::status_t status;

  // sequencer
  csgi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // store, walker, arithmetic, output register
  csgi_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .bin_index_i   (bin_index_i),
    .range_value_i (range_value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .range_out_o   (range_out_o),
    .source_o      (source_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
